>>> sv/qars_pkg.sv
package qars_pkg;

    // field and register widths
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned NCOMP    = 8;
    localparam int unsigned IDX_W    = 3;

    // normalization arithmetic
    localparam int unsigned RAD_W    = 50;
    localparam int unsigned ROOT_W   = 25;
    localparam int unsigned RT_REM_W = 27;
    localparam int unsigned RT_STEPS = 25;
    localparam int unsigned DV_REM_W = 25;
    localparam int unsigned DV_STEPS = 16;
    localparam logic [15:0] UNIT_Q14 = 16'd16384;

    // pipeline stage indices
    localparam int unsigned ST_IN   = 0;
    localparam int unsigned ST_SQ   = 1;
    localparam int unsigned ST_SUM  = 2;
    localparam int unsigned ST_RT0  = 3;
    localparam int unsigned ST_DSET = ST_RT0 + RT_STEPS;
    localparam int unsigned ST_DV0  = ST_DSET + 1;
    localparam int unsigned ST_NRM  = ST_DV0 + DV_STEPS;
    localparam int unsigned ST_MUL  = ST_NRM + 1;
    localparam int unsigned ST_ACC  = ST_MUL + 1;
    localparam int unsigned ST_GAIN = ST_ACC + 1;
    localparam int unsigned ST_SUMF = ST_GAIN + 1;
    localparam int unsigned ST_OUT  = ST_SUMF + 1;
    localparam int unsigned NSTAGE  = ST_OUT + 1;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ROLL_GAIN        = 3'd0,
        REG_PITCH_GAIN       = 3'd1,
        REG_ROLL_RATE_LIMIT  = 3'd2,
        REG_PITCH_RATE_LIMIT = 3'd3,
        REG_YAW_RATE_LIMIT   = 3'd4
    } reg_idx_t;

    localparam logic [15:0] RST_ROLL_GAIN        = 16'd26624;
    localparam logic [15:0] RST_PITCH_GAIN       = 16'd26624;
    localparam logic [15:0] RST_ROLL_RATE_LIMIT  = 16'd15729;
    localparam logic [15:0] RST_PITCH_RATE_LIMIT = 16'd15729;
    localparam logic [15:0] RST_YAW_RATE_LIMIT   = 16'd14298;

    // raw components (est w,x,y,z then goal w,x,y,z) and feedforward
    typedef struct packed {
        logic [NCOMP-1:0][FIELD_W-1:0] comp;
        logic [FIELD_W-1:0]            ff;
    } side_t;

endpackage

>>> sv/qars_if.sv
interface qars_att_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] est_w;
    logic signed [15:0] est_x;
    logic signed [15:0] est_y;
    logic signed [15:0] est_z;
    logic signed [15:0] goal_w;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic signed [15:0] goal_z;
    logic signed [15:0] yaw_rate_feed;

    modport source (
        output valid, est_w, est_x, est_y, est_z,
        output goal_w, goal_x, goal_y, goal_z, yaw_rate_feed,
        input  ready
    );
    modport sink (
        input  valid, est_w, est_x, est_y, est_z,
        input  goal_w, goal_x, goal_y, goal_z, yaw_rate_feed,
        output ready
    );
endinterface

interface qars_rate_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_rate_cmd;
    logic signed [15:0] pitch_rate_cmd;
    logic signed [15:0] yaw_rate_cmd;

    modport source (
        output valid, roll_rate_cmd, pitch_rate_cmd, yaw_rate_cmd,
        input  ready
    );
    modport sink (
        input  valid, roll_rate_cmd, pitch_rate_cmd, yaw_rate_cmd,
        output ready
    );
endinterface

interface qars_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> sv/quaternion_attitude_rate_setpoint_unit.sv
// throughput: one beat per cycle; each stage advances whenever it is empty or the next moves,
// so bubbles collapse and a stalled output only blocks input once all 51 stages are full
// depth is set by the 25-step square root and the 16-step divider, one bit per stage
// reset clears stage valid bits and loads the default gains and rate limits
module quaternion_attitude_rate_setpoint_unit
    import qars_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    qars_cfg_if.sink    cfg,
    qars_att_if.sink    att,
    qars_rate_if.source rate
);

    // output clamp: rate limit first, then 16-bit range
    function automatic logic [15:0] clamp_out(logic signed [22:0] r, logic [15:0] lim);
        logic signed [22:0] hi;
        logic signed [22:0] lo;
        logic signed [22:0] v;
        hi = {7'd0, lim};
        lo = -hi;
        v  = r;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        if (v > 23'sd32767) v = 23'sd32767;
        if (v < -23'sd32768) v = -23'sd32768;
        return v[15:0];
    endfunction

    function automatic logic nrm_in_range(logic [NCOMP-1:0][FIELD_W-1:0] v);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NCOMP; i++)
        begin
            if ($signed(v[i]) > 16'sd16384 || $signed(v[i]) < -16'sd16384) ok = 1'b0;
        end
        return ok;
    endfunction

    // configuration registers
    logic [15:0] roll_gain_reg;
    logic [15:0] pitch_gain_reg;
    logic [15:0] roll_lim_reg;
    logic [15:0] pitch_lim_reg;
    logic [15:0] yaw_lim_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_gain_reg  <= RST_ROLL_GAIN;
            pitch_gain_reg <= RST_PITCH_GAIN;
            roll_lim_reg   <= RST_ROLL_RATE_LIMIT;
            pitch_lim_reg  <= RST_PITCH_RATE_LIMIT;
            yaw_lim_reg    <= RST_YAW_RATE_LIMIT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ROLL_GAIN:        roll_gain_reg  <= cfg.data;
                REG_PITCH_GAIN:       pitch_gain_reg <= cfg.data;
                REG_ROLL_RATE_LIMIT:  roll_lim_reg   <= cfg.data;
                REG_PITCH_RATE_LIMIT: pitch_lim_reg  <= cfg.data;
                REG_YAW_RATE_LIMIT:   yaw_lim_reg    <= cfg.data;
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage advance
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] en;

    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_en
        assign en[k] = rate.ready || !(&vld_reg[NSTAGE-1:k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0]) vld_reg[0] <= att.valid;
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign att.ready  = en[ST_IN];
    assign rate.valid = vld_reg[ST_OUT];

    // input capture
    side_t in_side_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            in_side_reg.comp[0] <= att.est_w;
            in_side_reg.comp[1] <= att.est_x;
            in_side_reg.comp[2] <= att.est_y;
            in_side_reg.comp[3] <= att.est_z;
            in_side_reg.comp[4] <= att.goal_w;
            in_side_reg.comp[5] <= att.goal_x;
            in_side_reg.comp[6] <= att.goal_y;
            in_side_reg.comp[7] <= att.goal_z;
            in_side_reg.ff      <= att.yaw_rate_feed;
        end
    end

    // squares of the raw components
    logic signed [31:0]            sq_full [NCOMP];
    logic [NCOMP-1:0][30:0]        sq_reg;
    side_t                         sq_side_reg;

    always_comb
    begin
        for (int i = 0; i < NCOMP; i++)
        begin
            sq_full[i] = $signed(in_side_reg.comp[i]) * $signed(in_side_reg.comp[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SQ])
        begin
            for (int i = 0; i < NCOMP; i++)
            begin
                sq_reg[i] <= sq_full[i][30:0];
            end
            sq_side_reg <= in_side_reg;
        end
    end

    // squared norms, scaled by 2^16 as the root radicand
    logic [32:0]                   norm_sum [2];
    logic [1:0][RAD_W-1:0]         rad_reg;
    side_t                         sum_side_reg;

    always_comb
    begin
        for (int qi = 0; qi < 2; qi++)
        begin
            norm_sum[qi] = 33'(sq_reg[4*qi]) + 33'(sq_reg[4*qi+1])
                         + 33'(sq_reg[4*qi+2]) + 33'(sq_reg[4*qi+3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            for (int qi = 0; qi < 2; qi++)
            begin
                rad_reg[qi] <= {1'b0, norm_sum[qi], 16'd0};
            end
            sum_side_reg <= sq_side_reg;
        end
    end

    // square root, one result bit per stage
    logic [1:0][RAD_W-1:0]    rt_rad_reg  [RT_STEPS];
    logic [1:0][RT_REM_W-1:0] rt_rem_reg  [RT_STEPS];
    logic [1:0][ROOT_W-1:0]   rt_root_reg [RT_STEPS];
    side_t                    rt_side_reg [RT_STEPS];

    for (genvar k = 0; k < RT_STEPS; k++)
    begin : g_rt
        logic [1:0][RAD_W-1:0]    rad_in;
        logic [1:0][RT_REM_W-1:0] rem_in;
        logic [1:0][ROOT_W-1:0]   root_in;
        side_t                    side_in;
        logic [RT_REM_W+1:0]      cur   [2];
        logic [RT_REM_W+1:0]      trial [2];
        logic [1:0][RT_REM_W-1:0] rem_next;
        logic [1:0][ROOT_W-1:0]   root_next;

        if (k == 0)
        begin : g_first
            assign rad_in  = rad_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = sum_side_reg;
        end
        else
        begin : g_rest
            assign rad_in  = rt_rad_reg[k-1];
            assign rem_in  = rt_rem_reg[k-1];
            assign root_in = rt_root_reg[k-1];
            assign side_in = rt_side_reg[k-1];
        end

        always_comb
        begin
            for (int qi = 0; qi < 2; qi++)
            begin
                cur[qi]   = {rem_in[qi], rad_in[qi][RAD_W-1-2*k -: 2]};
                trial[qi] = (RT_REM_W+2)'({root_in[qi], 2'b01});
                if (cur[qi] >= trial[qi])
                begin
                    rem_next[qi]  = RT_REM_W'(cur[qi] - trial[qi]);
                    root_next[qi] = {root_in[qi][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[qi]  = cur[qi][RT_REM_W-1:0];
                    root_next[qi] = {root_in[qi][ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_RT0+k])
            begin
                rt_rad_reg[k]  <= rad_in;
                rt_rem_reg[k]  <= rem_next;
                rt_root_reg[k] <= root_next;
                rt_side_reg[k] <= side_in;
            end
        end
    end

    // divider setup: rounded numerator |c|*2^22 + n/2
    logic [15:0]                   ds_mag [NCOMP];
    logic [37:0]                   ds_num [NCOMP];
    logic [NCOMP-1:0][DV_REM_W-1:0] ds_rem_reg;
    logic [NCOMP-1:0][15:0]        ds_low_reg;
    logic [1:0][ROOT_W-1:0]        ds_n_reg;
    logic [NCOMP-1:0]              ds_neg_reg;
    logic [15:0]                   ds_ff_reg;

    always_comb
    begin
        for (int i = 0; i < NCOMP; i++)
        begin
            ds_mag[i] = rt_side_reg[RT_STEPS-1].comp[i][15]
                      ? (~rt_side_reg[RT_STEPS-1].comp[i] + 16'd1)
                      : rt_side_reg[RT_STEPS-1].comp[i];
            ds_num[i] = {ds_mag[i], 22'd0}
                      + 38'(rt_root_reg[RT_STEPS-1][i/4] >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DSET])
        begin
            for (int i = 0; i < NCOMP; i++)
            begin
                ds_rem_reg[i] <= DV_REM_W'(ds_num[i][37:16]);
                ds_low_reg[i] <= ds_num[i][15:0];
                ds_neg_reg[i] <= rt_side_reg[RT_STEPS-1].comp[i][15];
            end
            ds_n_reg  <= rt_root_reg[RT_STEPS-1];
            ds_ff_reg <= rt_side_reg[RT_STEPS-1].ff;
        end
    end

    // restoring division, one quotient bit per stage
    logic [NCOMP-1:0][DV_REM_W-1:0] dv_rem_reg [DV_STEPS];
    logic [NCOMP-1:0][15:0]         dv_low_reg [DV_STEPS];
    logic [1:0][ROOT_W-1:0]         dv_n_reg   [DV_STEPS];
    logic [NCOMP-1:0]               dv_neg_reg [DV_STEPS];
    logic [15:0]                    dv_ff_reg  [DV_STEPS];

    for (genvar k = 0; k < DV_STEPS; k++)
    begin : g_dv
        logic [NCOMP-1:0][DV_REM_W-1:0] rem_in;
        logic [NCOMP-1:0][15:0]         low_in;
        logic [1:0][ROOT_W-1:0]         n_in;
        logic [NCOMP-1:0]               neg_in;
        logic [15:0]                    ff_in;
        logic [DV_REM_W:0]              cur [NCOMP];
        logic [DV_REM_W:0]              dvs [NCOMP];
        logic [NCOMP-1:0][DV_REM_W-1:0] rem_next;
        logic [NCOMP-1:0][15:0]         low_next;

        if (k == 0)
        begin : g_first
            assign rem_in = ds_rem_reg;
            assign low_in = ds_low_reg;
            assign n_in   = ds_n_reg;
            assign neg_in = ds_neg_reg;
            assign ff_in  = ds_ff_reg;
        end
        else
        begin : g_rest
            assign rem_in = dv_rem_reg[k-1];
            assign low_in = dv_low_reg[k-1];
            assign n_in   = dv_n_reg[k-1];
            assign neg_in = dv_neg_reg[k-1];
            assign ff_in  = dv_ff_reg[k-1];
        end

        always_comb
        begin
            for (int i = 0; i < NCOMP; i++)
            begin
                cur[i] = {rem_in[i], low_in[i][15]};
                dvs[i] = (DV_REM_W+1)'(n_in[i/4]);
                if (cur[i] >= dvs[i])
                begin
                    rem_next[i] = DV_REM_W'(cur[i] - dvs[i]);
                    low_next[i] = {low_in[i][14:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = cur[i][DV_REM_W-1:0];
                    low_next[i] = {low_in[i][14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_DV0+k])
            begin
                dv_rem_reg[k] <= rem_next;
                dv_low_reg[k] <= low_next;
                dv_n_reg[k]   <= n_in;
                dv_neg_reg[k] <= neg_in;
                dv_ff_reg[k]  <= ff_in;
            end
        end
    end

    // unit components: clamp, restore sign, zero-norm gives zero
    logic [15:0]                   nm_mag [NCOMP];
    logic [NCOMP-1:0][FIELD_W-1:0] nm_next;
    logic [NCOMP-1:0][FIELD_W-1:0] nm_reg;
    logic [15:0]                   nm_ff_reg;

    always_comb
    begin
        for (int i = 0; i < NCOMP; i++)
        begin
            nm_mag[i] = (dv_low_reg[DV_STEPS-1][i] > UNIT_Q14)
                      ? UNIT_Q14 : dv_low_reg[DV_STEPS-1][i];
            if (dv_n_reg[DV_STEPS-1][i/4] == '0)
                nm_next[i] = '0;
            else if (dv_neg_reg[DV_STEPS-1][i])
                nm_next[i] = ~nm_mag[i] + 16'd1;
            else
                nm_next[i] = nm_mag[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_NRM])
        begin
            nm_reg    <= nm_next;
            nm_ff_reg <= dv_ff_reg[DV_STEPS-1];
        end
    end

    // cross products q_i*p_j and the rotation-row products
    logic signed [31:0] qp_full [4][4];
    logic signed [31:0] qq_full [6];
    logic signed [29:0] qp_reg  [4][4];
    logic signed [29:0] qq_reg  [6];
    logic [15:0]        mul_ff_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                qp_full[i][j] = $signed(nm_reg[i]) * $signed(nm_reg[4+j]);
            end
        end
        qq_full[0] = $signed(nm_reg[1]) * $signed(nm_reg[3]);
        qq_full[1] = $signed(nm_reg[0]) * $signed(nm_reg[2]);
        qq_full[2] = $signed(nm_reg[2]) * $signed(nm_reg[3]);
        qq_full[3] = $signed(nm_reg[0]) * $signed(nm_reg[1]);
        qq_full[4] = $signed(nm_reg[1]) * $signed(nm_reg[1]);
        qq_full[5] = $signed(nm_reg[2]) * $signed(nm_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    qp_reg[i][j] <= qp_full[i][j][29:0];
                end
            end
            for (int i = 0; i < 6; i++)
            begin
                qq_reg[i] <= qq_full[i][29:0];
            end
            mul_ff_reg <= nm_ff_reg;
        end
    end

    // error quaternion conj(q)*qd and third row of R(q)
    logic signed [31:0] err_w;
    logic signed [31:0] err_v  [3];
    logic signed [31:0] row_v  [3];
    logic signed [31:0] acc_e_reg [3];
    logic signed [31:0] acc_r_reg [3];
    logic               acc_neg_reg;
    logic [15:0]        acc_ff_reg;

    always_comb
    begin
        err_w    = 32'(qp_reg[0][0]) + 32'(qp_reg[1][1]) + 32'(qp_reg[2][2])
                 + 32'(qp_reg[3][3]);
        err_v[0] = 32'(qp_reg[0][1]) - 32'(qp_reg[1][0]) - 32'(qp_reg[2][3])
                 + 32'(qp_reg[3][2]);
        err_v[1] = 32'(qp_reg[0][2]) + 32'(qp_reg[1][3]) - 32'(qp_reg[2][0])
                 - 32'(qp_reg[3][1]);
        err_v[2] = 32'(qp_reg[0][3]) - 32'(qp_reg[1][2]) + 32'(qp_reg[2][1])
                 - 32'(qp_reg[3][0]);
        row_v[0] = (32'(qq_reg[0]) - 32'(qq_reg[1])) <<< 1;
        row_v[1] = (32'(qq_reg[2]) + 32'(qq_reg[3])) <<< 1;
        row_v[2] = 32'sd268435456 - ((32'(qq_reg[4]) + 32'(qq_reg[5])) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_ACC])
        begin
            for (int a = 0; a < 3; a++)
            begin
                acc_e_reg[a] <= err_v[a];
                acc_r_reg[a] <= row_v[a];
            end
            acc_neg_reg <= err_w[31];
            acc_ff_reg  <= mul_ff_reg;
        end
    end

    // gain and feedforward products, sign of qe.w folded into the gain
    logic [16:0]        gain_u   [3];
    logic signed [17:0] gain_pos [3];
    logic signed [17:0] gain_s   [3];
    logic signed [49:0] pe_full  [3];
    logic signed [47:0] pf_full  [3];
    logic signed [49:0] pe_reg   [3];
    logic signed [47:0] pf_reg   [3];

    always_comb
    begin
        gain_u[0] = {roll_gain_reg, 1'b0};
        gain_u[1] = {pitch_gain_reg, 1'b0};
        gain_u[2] = 17'(roll_gain_reg) + 17'(pitch_gain_reg);
        for (int a = 0; a < 3; a++)
        begin
            gain_pos[a] = {1'b0, gain_u[a]};
            gain_s[a]   = acc_neg_reg ? -gain_pos[a] : gain_pos[a];
            pe_full[a]  = acc_e_reg[a] * gain_s[a];
            pf_full[a]  = acc_r_reg[a] * $signed(acc_ff_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_GAIN])
        begin
            for (int a = 0; a < 3; a++)
            begin
                pe_reg[a] <= pe_full[a];
                pf_reg[a] <= pf_full[a];
            end
        end
    end

    // Q40 sum plus half an output lsb
    logic signed [50:0] sum_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[ST_SUMF])
        begin
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= 51'(pe_reg[a]) + 51'(pf_reg[a]) + 51'sd134217728;
            end
        end
    end

    // floor to Q12, clamp, output register
    logic [15:0] out_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            out_reg[0] <= clamp_out(sum_reg[0][50:28], roll_lim_reg);
            out_reg[1] <= clamp_out(sum_reg[1][50:28], pitch_lim_reg);
            out_reg[2] <= clamp_out(sum_reg[2][50:28], yaw_lim_reg);
        end
    end

    assign rate.roll_rate_cmd  = out_reg[0];
    assign rate.pitch_rate_cmd = out_reg[1];
    assign rate.yaw_rate_cmd   = out_reg[2];

    // a zero root can only come from an all-zero estimate
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DSET-1] && rt_root_reg[RT_STEPS-1][0] == '0
        |-> rt_side_reg[RT_STEPS-1].comp[3:0] == '0)
        else $error("zero root from nonzero estimate");

    // normalized components stay within the unit range
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_NRM] |-> nrm_in_range(nm_reg))
        else $error("normalized component out of range");

    // input is refused only with a full pipeline behind a stalled output
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !att.ready |-> (&vld_reg) && !rate.ready)
        else $error("input refused with room in the pipeline");

endmodule

>>> test/quaternion_attitude_rate_setpoint_unit_tb.sv
module quaternion_attitude_rate_setpoint_unit_tb;
    import qars_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] est [4];
        logic signed [15:0] goal [4];
        logic signed [15:0] ff;
    } att_beat_t;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } rate_beat_t;

    // setpoint predictor and queue of pending rate beats
    class rate_setpoint_board;
        logic [15:0] roll_gain, pitch_gain, roll_lim, pitch_lim, yaw_lim;
        rate_beat_t  pending [$];
        int          errors;
        int          matched;

        function new();
            roll_gain = RST_ROLL_GAIN;
            pitch_gain = RST_PITCH_GAIN;
            roll_lim = RST_ROLL_RATE_LIMIT;
            pitch_lim = RST_PITCH_RATE_LIMIT;
            yaw_lim = RST_YAW_RATE_LIMIT;
            errors = 0;
            matched = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [15:0] val);
            case (idx)
                REG_ROLL_GAIN:        roll_gain = val;
                REG_PITCH_GAIN:       pitch_gain = val;
                REG_ROLL_RATE_LIMIT:  roll_lim = val;
                REG_PITCH_RATE_LIMIT: pitch_lim = val;
                REG_YAW_RATE_LIMIT:   yaw_lim = val;
                default: ;
            endcase
        endfunction

        // integer square root, bit by bit
        function longint unsigned int_root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void unit_quat(input logic signed [15:0] c [4], output longint u [4]);
            longint unsigned s, n, mag, q;
            longint v;
            s = 0;
            for (int i = 0; i < 4; i++)
            begin
                v = c[i];
                s += v * v;
            end
            if (s == 0)
            begin
                for (int i = 0; i < 4; i++) u[i] = 0;
                return;
            end
            n = int_root(s << 16);
            for (int i = 0; i < 4; i++)
            begin
                v = c[i];
                mag = v < 0 ? -v : v;
                q = ((mag << 22) + n / 2) / n;
                if (q > 16384) q = 16384;
                u[i] = v < 0 ? -longint'(q) : longint'(q);
            end
        endfunction

        // round q40 to q12 with ties up, then clamp to limit and output range
        function logic signed [15:0] round_clamp(longint v40, logic [15:0] lim);
            longint r, l;
            r = (v40 + (64'sd1 <<< 27)) >>> 28;
            l = lim;
            if (r > l) r = l;
            if (r < -l) r = -l;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        endfunction

        function void note_attitude(att_beat_t a);
            longint q [4];
            longint p [4];
            longint ew, ex, ey, ez, sg, ff, g0, g1, r0, r1, r2;
            rate_beat_t e;
            unit_quat(a.est, q);
            unit_quat(a.goal, p);
            ew = q[0]*p[0] + q[1]*p[1] + q[2]*p[2] + q[3]*p[3];
            ex = q[0]*p[1] - q[1]*p[0] - q[2]*p[3] + q[3]*p[2];
            ey = q[0]*p[2] + q[1]*p[3] - q[2]*p[0] - q[3]*p[1];
            ez = q[0]*p[3] - q[1]*p[2] + q[2]*p[1] - q[3]*p[0];
            sg = ew >= 0 ? 1 : -1;
            ff = a.ff;
            g0 = roll_gain;
            g1 = pitch_gain;
            r0 = 2 * (q[1]*q[3] - q[0]*q[2]);
            r1 = 2 * (q[2]*q[3] + q[0]*q[1]);
            r2 = (64'sd1 <<< 28) - 2 * (q[1]*q[1] + q[2]*q[2]);
            e.roll = round_clamp(sg * ex * (2 * g0) + r0 * ff, roll_lim);
            e.pitch = round_clamp(sg * ey * (2 * g1) + r1 * ff, pitch_lim);
            e.yaw = round_clamp(sg * ez * (g0 + g1) + r2 * ff, yaw_lim);
            pending.push_back(e);
        endfunction

        function void check_rate(rate_beat_t got);
            rate_beat_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected rate beat %0d %0d %0d", $time,
                         got.roll, got.pitch, got.yaw);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.roll !== e.roll)
            begin
                $display("%0t roll exp %0d got %0d", $time, e.roll, got.roll);
                errors++;
            end
            if (got.pitch !== e.pitch)
            begin
                $display("%0t pitch exp %0d got %0d", $time, e.pitch, got.pitch);
                errors++;
            end
            if (got.yaw !== e.yaw)
            begin
                $display("%0t yaw exp %0d got %0d", $time, e.yaw, got.yaw);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_off;
    int   sent;

    qars_cfg_if  cfg ();
    qars_att_if  att ();
    qars_rate_if rate ();

    rate_setpoint_board board;

    quaternion_attitude_rate_setpoint_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .att   (att.sink),
        .rate  (rate.source)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4ms;
        $display("status: fail");
        $finish;
    end

    // input monitor
    always @(posedge clk)
    begin
        att_beat_t a;
        if (rst_n && att.valid && att.ready)
        begin
            a.est[0] = att.est_w;
            a.est[1] = att.est_x;
            a.est[2] = att.est_y;
            a.est[3] = att.est_z;
            a.goal[0] = att.goal_w;
            a.goal[1] = att.goal_x;
            a.goal[2] = att.goal_y;
            a.goal[3] = att.goal_z;
            a.ff = att.yaw_rate_feed;
            board.note_attitude(a);
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        rate_beat_t r;
        if (rst_n && rate.valid && rate.ready)
        begin
            r.roll = rate.roll_rate_cmd;
            r.pitch = rate.pitch_rate_cmd;
            r.yaw = rate.yaw_rate_cmd;
            board.check_rate(r);
        end
    end

    // receiver ready, with random stalls and a long hold-off
    initial
    begin
        rate.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                rate.ready <= 1'b0;
                repeat (150) @(negedge clk);
                hold_off = 1'b0;
            end
            rate.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays high between back-to-back writes; set_cfg drops it
    task automatic write_cfg(reg_idx_t idx, logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        board.write_reg(idx, val);
        @(negedge clk);
    endtask

    // valid stays high after the beat; the next call or drain decides
    task automatic send_att(logic signed [15:0] c [8], logic signed [15:0] ff);
        while ($urandom_range(99) < send_idle_pct)
        begin
            att.valid <= 1'b0;
            @(negedge clk);
        end
        att.valid <= 1'b1;
        att.est_w <= c[0];
        att.est_x <= c[1];
        att.est_y <= c[2];
        att.est_z <= c[3];
        att.goal_w <= c[4];
        att.goal_x <= c[5];
        att.goal_y <= c[6];
        att.goal_z <= c[7];
        att.yaw_rate_feed <= ff;
        do @(posedge clk); while (!att.ready);
        @(negedge clk);
        sent++;
    endtask

    // waits until every pending rate beat has come, then the pipe drains
    task automatic drain();
        int t;
        t = 0;
        att.valid <= 1'b0;
        while (board.pending.size() != 0 && t < 200000)
        begin
            @(negedge clk);
            t++;
        end
        repeat (60) @(negedge clk);
    endtask

    // random attitude: mostly components within +/-8192, some raw noise, some tiny or zero
    task automatic send_random();
        logic signed [15:0] c [8];
        int k;
        k = $urandom_range(9);
        for (int i = 0; i < 8; i++)
        begin
            if (k < 6)
                c[i] = $signed(16'($urandom_range(16384))) - 16'sd8192;
            else if (k < 9)
                c[i] = 16'($urandom);
            else
                c[i] = ($urandom_range(3) == 0) ? 16'sd0 : 16'($urandom_range(3));
        end
        if (k == 9 && $urandom_range(1)) for (int i = 0; i < 4; i++) c[i] = 0;
        send_att(c, ($urandom_range(3) == 0) ? 16'($urandom)
                                             : 16'($signed(16'($urandom_range(16383))) - 8191));
    endtask

    task automatic set_cfg(logic [15:0] v [5]);
        write_cfg(REG_ROLL_GAIN, v[0]);
        write_cfg(REG_PITCH_GAIN, v[1]);
        write_cfg(REG_ROLL_RATE_LIMIT, v[2]);
        write_cfg(REG_PITCH_RATE_LIMIT, v[3]);
        write_cfg(REG_YAW_RATE_LIMIT, v[4]);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        logic signed [15:0] c [8];
        logic [15:0] v [5];
        board = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b0;
        sent = 0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        att.valid = 1'b0;
        att.est_w = '0; att.est_x = '0; att.est_y = '0; att.est_z = '0;
        att.goal_w = '0; att.goal_x = '0; att.goal_y = '0; att.goal_z = '0;
        att.yaw_rate_feed = '0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: identity, zero norms, extremes, opposite hemisphere
        c = '{16384, 0, 0, 0, 16384, 0, 0, 0};
        send_att(c, 16'sd0);
        send_att(c, 16'sd32767);
        send_att(c, -16'sd32768);
        c = '{0, 0, 0, 0, 16384, 2000, -3000, 1000};
        send_att(c, 16'sd4096);
        c = '{16384, 500, 500, 500, 0, 0, 0, 0};
        send_att(c, -16'sd4096);
        c = '{0, 0, 0, 0, 0, 0, 0, 0};
        send_att(c, 16'sd1234);
        c = '{32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768};
        send_att(c, 16'sd32767);
        c = '{-32768, 0, 0, 0, 0, 0, 0, 32767};
        send_att(c, -16'sd1);
        c = '{16384, 0, 0, 0, -16384, 100, -100, 50};
        send_att(c, 16'sd0);
        c = '{1, 0, 0, 0, 0, 1, 0, 0};
        send_att(c, 16'sd1);
        c = '{11585, 11585, 0, 0, 11585, 0, 11585, 0};
        send_att(c, 16'sd8192);
        c = '{0, 16384, 0, 0, 0, 0, 16384, 0};
        send_att(c, -16'sd8192);
        c = '{-1, -1, -1, -1, 1, 1, 1, 1};
        send_att(c, 16'sd5);
        c = '{16384, 0, 0, 0, 0, 0, 0, 16384};
        send_att(c, 16'sd0);
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                1: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                2: v = '{16'd0, 16'hFFFF, 16'd100, 16'h8000, 16'd32767};
                3: v = '{16'h5555, 16'hAAAA, 16'd32768, 16'd1, 16'd4096};
                default:
                    for (int i = 0; i < 5; i++) v[i] = 16'($urandom);
            endcase
            set_cfg(v);
            if (ph < 3)
            begin
                send_idle_pct = 23;
                recv_idle_pct = 87;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 6) hold_off = 1'b1;
            for (int n = 0; n < 200; n++)
            begin
                send_random();
                if (n == 100) drain();
            end
            drain();
        end

        repeat (60) @(negedge clk);
        $display("%0d attitude beats sent, %0d rate beats checked", sent, board.matched);
        $display("covered zero-norm, extreme, hemisphere-flip and register extreme cases");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
